FILE: sv/y2r_pkg.sv
`default_nettype none

package y2r_pkg;

    // One byte of a sample or of a color channel.
    typedef logic [7:0] t_byte;

    // Number of pixels in one 2x2 block.
    localparam int NPIX = 4;

    // BT.601 coefficients, scaled by 65536.
    localparam logic [16:0]        C_Y   = 17'd76310;
    localparam logic signed [18:0] C_R_V = 19'sd104635;
    localparam logic signed [18:0] C_G_U = -19'sd25690;
    localparam logic signed [18:0] C_G_V = -19'sd53294;
    localparam logic signed [18:0] C_B_U = 19'sd132278;

    // Offset removed from luma before scaling.
    localparam t_byte Y_OFS = 8'd16;

    // Scaled luma term: 76310 * 239 fits in 25 bits.
    typedef logic [24:0] t_luma_p;
    // Scaled chroma term: 132278 * -128 needs 26 signed bits.
    typedef logic signed [25:0] t_chroma_p;
    // Channel sum before saturation.
    typedef logic signed [26:0] t_sum;

    // Input block as it enters the pipeline.
    typedef struct packed {
        logic [NPIX-1:0][7:0] luma;
        t_byte                u;
        t_byte                v;
    } t_yuv;

    // After offset removal: clamped luma and signed chroma.
    typedef struct packed {
        logic [NPIX-1:0][7:0] y;
        logic signed [7:0]    u;
        logic signed [7:0]    v;
    } t_prep;

    // After the multipliers.
    typedef struct packed {
        logic [NPIX-1:0][24:0] l;
        t_chroma_p             rv;
        t_chroma_p             gu;
        t_chroma_p             gv;
        t_chroma_p             bu;
    } t_prod;

    // Chroma terms in output byte order.
    typedef struct packed {
        logic [NPIX-1:0][24:0] l;
        t_chroma_p             c_first;
        t_chroma_p             c_grn;
        t_chroma_p             c_third;
    } t_mix;

    // Four pixels, three bytes each; byte 0 is the first byte.
    typedef struct packed {
        logic [NPIX-1:0][2:0][7:0] px;
    } t_rgb;

    // Saturate a channel sum to a byte: above 0xffffff gives 255, a
    // negative sum or one up to 0xffff gives 0, otherwise bits 23..16.
    function automatic t_byte sat_byte(input t_sum s);
        t_byte b;
        if (s[26]) begin
            b = '0;
        end else if (s[25:24] != 2'b00) begin
            b = 8'hff;
        end else begin
            b = s[23:16];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/y2r_if.sv
`default_nettype none

// Channel carrying one 4:2:0 block per beat.
interface y2r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;

    modport source (
        output valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_u, chroma_v,
        input  ready
    );
    modport sink (
        input  valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_u, chroma_v,
        output ready
    );
endinterface

// Channel carrying four 24-bit pixels per beat.
interface y2r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tl_first;
    logic [7:0] tl_second;
    logic [7:0] tl_third;
    logic [7:0] tr_first;
    logic [7:0] tr_second;
    logic [7:0] tr_third;
    logic [7:0] bl_first;
    logic [7:0] bl_second;
    logic [7:0] bl_third;
    logic [7:0] br_first;
    logic [7:0] br_second;
    logic [7:0] br_third;

    modport source (
        output valid, tl_first, tl_second, tl_third, tr_first, tr_second,
               tr_third, bl_first, bl_second, bl_third, br_first, br_second,
               br_third,
        input  ready
    );
    modport sink (
        input  valid, tl_first, tl_second, tl_third, tr_first, tr_second,
               tr_third, bl_first, bl_second, bl_third, br_first, br_second,
               br_third,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/yuv420_to_rgb24_block.sv
// Channel   Dir  Beat contents
// i_yuv     in   four luma samples of a 2x2 block, shared chroma_u, chroma_v
// o_rgb     out  four pixels, bytes first/second/third (R,G,B or B,G,R)
// i_cfg_*   in   blue_first, one bit, written when i_cfg_we is high
//
// One block enters per cycle while i_yuv.ready is high; an accepted block
// reaches o_rgb.valid through the four register stages (offset, multiply,
// chroma mix, sum and saturate). Synchronous active-low reset empties the
// pipeline and sets blue_first to 1. A stall on o_rgb holds each full stage
// with no gap after it; i_yuv.ready stays high while any stage has room.
`default_nettype none

module yuv420_to_rgb24_block (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    y2r_in_if.sink    i_yuv,
    y2r_out_if.source o_rgb,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata
);
    import y2r_pkg::*;

    logic  r_blue_first;
    t_yuv  w_yuv;
    logic  w_v2;
    logic  w_r2;
    t_prod w_prod;
    logic  w_v3;
    logic  w_r3;
    t_mix  w_mix;
    t_rgb  w_rgb;

    // Byte order register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blue_first <= 1'b1;
        end else if (i_cfg_we) begin
            r_blue_first <= i_cfg_wdata;
        end
    end

    // Gather the input beat.
    assign w_yuv.luma[0] = i_yuv.luma_top_left;
    assign w_yuv.luma[1] = i_yuv.luma_top_right;
    assign w_yuv.luma[2] = i_yuv.luma_bottom_left;
    assign w_yuv.luma[3] = i_yuv.luma_bottom_right;
    assign w_yuv.u       = i_yuv.chroma_u;
    assign w_yuv.v       = i_yuv.chroma_v;

    y2r_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_yuv.valid),
        .o_rdy   (i_yuv.ready),
        .i_yuv   (w_yuv),
        .o_vld   (w_v2),
        .i_rdy   (w_r2),
        .o_prod  (w_prod)
    );

    y2r_mix u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blue_first (r_blue_first),
        .i_vld        (w_v2),
        .o_rdy        (w_r2),
        .i_prod       (w_prod),
        .o_vld        (w_v3),
        .i_rdy        (w_r3),
        .o_mix        (w_mix)
    );

    y2r_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_v3),
        .o_rdy   (w_r3),
        .i_mix   (w_mix),
        .o_vld   (o_rgb.valid),
        .i_rdy   (o_rgb.ready),
        .o_rgb   (w_rgb)
    );

    // Spread the output beat over the channel fields.
    assign o_rgb.tl_first  = w_rgb.px[0][0];
    assign o_rgb.tl_second = w_rgb.px[0][1];
    assign o_rgb.tl_third  = w_rgb.px[0][2];
    assign o_rgb.tr_first  = w_rgb.px[1][0];
    assign o_rgb.tr_second = w_rgb.px[1][1];
    assign o_rgb.tr_third  = w_rgb.px[1][2];
    assign o_rgb.bl_first  = w_rgb.px[2][0];
    assign o_rgb.bl_second = w_rgb.px[2][1];
    assign o_rgb.bl_third  = w_rgb.px[2][2];
    assign o_rgb.br_first  = w_rgb.px[3][0];
    assign o_rgb.br_second = w_rgb.px[3][1];
    assign o_rgb.br_third  = w_rgb.px[3][2];

endmodule

`default_nettype wire

FILE: sv/y2r_prod.sv
`default_nettype none

// Stages 1 and 2: offset removal, then the luma and chroma multipliers.
module y2r_prod (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire y2r_pkg::t_yuv i_yuv,
    output logic               o_vld,
    input  wire logic          i_rdy,
    output y2r_pkg::t_prod     o_prod
);
    import y2r_pkg::*;

    logic  r_v1;
    t_prep r_p1;
    t_prep n_p1;
    logic  rdy1;

    logic  r_v2;
    t_prod r_p2;
    t_prod n_p2;
    logic  rdy2;

    logic signed [27:0] w_rv;
    logic signed [27:0] w_gu;
    logic signed [27:0] w_gv;
    logic signed [27:0] w_bu;

    // A stage takes a new beat when it is empty or its beat moves on.
    assign rdy2  = !r_v2 || i_rdy;
    assign rdy1  = !r_v1 || rdy2;
    assign o_rdy = rdy1;

    // Luma below 16 clamps to zero; chroma minus 128 is the byte with its
    // top bit inverted.
    always_comb begin
        for (int k = 0; k < NPIX; k++) begin
            n_p1.y[k] = (i_yuv.luma[k] < Y_OFS) ? 8'd0 : (i_yuv.luma[k] - Y_OFS);
        end
        n_p1.u = {~i_yuv.u[7], i_yuv.u[6:0]};
        n_p1.v = {~i_yuv.v[7], i_yuv.v[6:0]};
    end

    // Products: one per luma sample and one per chroma coefficient.
    always_comb begin
        for (int k = 0; k < NPIX; k++) begin
            n_p2.l[k] = 25'(C_Y) * 25'(r_p1.y[k]);
        end
        w_rv = 28'(C_R_V) * 28'(r_p1.v);
        w_gu = 28'(C_G_U) * 28'(r_p1.u);
        w_gv = 28'(C_G_V) * 28'(r_p1.v);
        w_bu = 28'(C_B_U) * 28'(r_p1.u);
        n_p2.rv = w_rv[25:0];
        n_p2.gu = w_gu[25:0];
        n_p2.gv = w_gv[25:0];
        n_p2.bu = w_bu[25:0];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_vld;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload registers load only with a beat.
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_vld) begin
            r_p1 <= n_p1;
        end
        if (rdy2 && r_v1) begin
            r_p2 <= n_p2;
        end
    end

    assign o_vld  = r_v2;
    assign o_prod = r_p2;

endmodule

`default_nettype wire

FILE: sv/y2r_mix.sv
`default_nettype none

// Stage 3: green chroma sum and the red/blue order swap.
module y2r_mix (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_blue_first,
    input  wire logic           i_vld,
    output logic                o_rdy,
    input  wire y2r_pkg::t_prod i_prod,
    output logic                o_vld,
    input  wire logic           i_rdy,
    output y2r_pkg::t_mix       o_mix
);
    import y2r_pkg::*;

    logic r_v3;
    t_mix r_p3;
    t_mix n_p3;

    assign o_rdy = !r_v3 || i_rdy;

    // Put the chroma terms in the order the bytes leave.
    always_comb begin
        n_p3.l       = i_prod.l;
        n_p3.c_grn   = i_prod.gu + i_prod.gv;
        n_p3.c_first = i_blue_first ? i_prod.bu : i_prod.rv;
        n_p3.c_third = i_blue_first ? i_prod.rv : i_prod.bu;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (o_rdy) begin
            r_v3 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_p3 <= n_p3;
        end
    end

    assign o_vld = r_v3;
    assign o_mix = r_p3;

endmodule

`default_nettype wire

FILE: sv/y2r_sat.sv
`default_nettype none

// Stage 4: channel sums, saturation and the output register.
module y2r_sat (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire y2r_pkg::t_mix i_mix,
    output logic               o_vld,
    input  wire logic          i_rdy,
    output y2r_pkg::t_rgb      o_rgb
);
    import y2r_pkg::*;

    logic r_v4;
    t_rgb r_p4;
    t_rgb n_p4;
    t_sum w_l;

    assign o_rdy = !r_v4 || i_rdy;

    // Add the luma term to each chroma term and clip to a byte.
    always_comb begin
        w_l = '0;
        for (int k = 0; k < NPIX; k++) begin
            w_l = t_sum'({2'b00, i_mix.l[k]});
            n_p4.px[k][0] = sat_byte(w_l + t_sum'(i_mix.c_first));
            n_p4.px[k][1] = sat_byte(w_l + t_sum'(i_mix.c_grn));
            n_p4.px[k][2] = sat_byte(w_l + t_sum'(i_mix.c_third));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (o_rdy) begin
            r_v4 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_p4 <= n_p4;
        end
    end

    assign o_vld = r_v4;
    assign o_rgb = r_p4;

endmodule

`default_nettype wire

FILE: sv/y2r_chk.sv
`default_nettype none

// Port-level checks on the converter.
module y2r_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [95:0] i_out_data
);
    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    // A waiting output beat stays and keeps its bytes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output beat dropped or changed under stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // With the output draining, the input never stalls.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

    // With the output draining, a beat is valid at the output once it has crossed the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("beat did not arrive after four cycles");

endmodule

bind yuv420_to_rgb24_block y2r_chk u_y2r_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_yuv.valid),
    .i_in_ready  (i_yuv.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_out_data  ({o_rgb.tl_first, o_rgb.tl_second, o_rgb.tl_third,
                   o_rgb.tr_first, o_rgb.tr_second, o_rgb.tr_third,
                   o_rgb.bl_first, o_rgb.bl_second, o_rgb.bl_third,
                   o_rgb.br_first, o_rgb.br_second, o_rgb.br_third})
);

`default_nettype wire

FILE: bench/yuv420_to_rgb24_block_tb.sv
`timescale 1ns / 100ps

module yuv420_to_rgb24_block_tb;
    import y2r_pkg::*;

    // BT.601 coefficients scaled by 65536, and the sample offsets.
    localparam int COEF_LUMA    = 76310;
    localparam int COEF_RED_V   = 104635;
    localparam int COEF_GREEN_U = -25690;
    localparam int COEF_GREEN_V = -53294;
    localparam int COEF_BLUE_U  = 132278;
    localparam int CHROMA_MID   = 128;
    localparam int LUMA_FLOOR   = 16;
    localparam int PIPE_DEPTH   = 4;

    // Holds the pixels each accepted block should produce, oldest first.
    class yuv_block_checker;
        t_rgb expected_pixels[$];
        int   fails;

        function new();
            fails = 0;
        endfunction

        task report(input string what);
            if (fails < 100) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
            fails++;
        endtask

        // Clamp a scaled channel sum to one byte; negative sums give zero.
        function t_byte saturate_channel(input int s);
            if (s > 32'sh00ffffff) begin
                return 8'hff;
            end
            if (s <= 32'sh0000ffff) begin
                return 8'h00;
            end
            return t_byte'(s >>> 16);
        endfunction

        // Convert one 2x2 block with its shared chroma to four pixels.
        function t_rgb convert_block(input t_yuv blk, input logic blue_first);
            t_rgb px_out;
            int cu;
            int cv;
            int red_term;
            int green_term;
            int blue_term;
            int lum;
            cu = int'(blk.u) - CHROMA_MID;
            cv = int'(blk.v) - CHROMA_MID;
            red_term   = COEF_RED_V * cv;
            green_term = COEF_GREEN_U * cu + COEF_GREEN_V * cv;
            blue_term  = COEF_BLUE_U * cu;
            for (int k = 0; k < NPIX; k++) begin
                lum = int'(blk.luma[k]) - LUMA_FLOOR;
                if (lum < 0) begin
                    lum = 0;
                end
                lum = lum * COEF_LUMA;
                px_out.px[k][0] = saturate_channel(lum + (blue_first ? blue_term : red_term));
                px_out.px[k][1] = saturate_channel(lum + green_term);
                px_out.px[k][2] = saturate_channel(lum + (blue_first ? red_term : blue_term));
            end
            return px_out;
        endfunction

        function void note_block(input t_yuv blk, input logic blue_first);
            expected_pixels.push_back(convert_block(blk, blue_first));
        endfunction

        task check_pixels(input t_rgb got);
            string corner[NPIX];
            string slot[3];
            t_rgb  want;
            corner = '{"tl", "tr", "bl", "br"};
            slot   = '{"first", "second", "third"};
            if (expected_pixels.size() == 0) begin
                report("output beat with no block outstanding");
            end else begin
                want = expected_pixels.pop_front();
                for (int k = 0; k < NPIX; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        if (got.px[k][j] !== want.px[k][j]) begin
                            report($sformatf("%s_%s got %0d expected %0d", corner[k],
                                             slot[j], got.px[k][j], want.px[k][j]));
                        end
                    end
                end
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic blue_first_now;
    int   ready_cycle;
    int   stall_left;

    yuv_block_checker board;

    y2r_in_if  yuv_if ();
    y2r_out_if rgb_if ();

    yuv420_to_rgb24_block uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_yuv       (yuv_if),
        .o_rgb       (rgb_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls in random bursts during the early part of each window
    // counted by ready_cycle and stays ready for the rest.
    always @(posedge clk) begin
        ready_cycle <= ready_cycle + 1;
        if (stall_left != 0) begin
            rgb_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ((ready_cycle % 300) < 200 && $urandom_range(0, 4) == 0) begin
            rgb_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 7);
        end else begin
            rgb_if.ready <= 1'b1;
        end
    end

    // Note each accepted input beat and check each accepted output beat.
    always @(posedge clk) begin
        t_yuv blk;
        t_rgb got;
        if (rst_n && yuv_if.valid && yuv_if.ready) begin
            blk.luma[0] = yuv_if.luma_top_left;
            blk.luma[1] = yuv_if.luma_top_right;
            blk.luma[2] = yuv_if.luma_bottom_left;
            blk.luma[3] = yuv_if.luma_bottom_right;
            blk.u       = yuv_if.chroma_u;
            blk.v       = yuv_if.chroma_v;
            board.note_block(blk, blue_first_now);
        end
        if (rst_n && rgb_if.valid && rgb_if.ready) begin
            got.px[0] = {rgb_if.tl_third, rgb_if.tl_second, rgb_if.tl_first};
            got.px[1] = {rgb_if.tr_third, rgb_if.tr_second, rgb_if.tr_first};
            got.px[2] = {rgb_if.bl_third, rgb_if.bl_second, rgb_if.bl_first};
            got.px[3] = {rgb_if.br_third, rgb_if.br_second, rgb_if.br_first};
            board.check_pixels(got);
        end
    end

    function automatic t_yuv make_block(input t_byte tl, input t_byte tr, input t_byte bl,
                                        input t_byte br, input t_byte u, input t_byte v);
        t_yuv blk;
        blk.luma[0] = tl;
        blk.luma[1] = tr;
        blk.luma[2] = bl;
        blk.luma[3] = br;
        blk.u       = u;
        blk.v       = v;
        return blk;
    endfunction

    // Mostly uniform bytes, with a share of values at the clamp and saturation edges.
    function automatic t_byte random_sample();
        t_byte edges[7];
        edges = '{8'd0, 8'd15, 8'd16, 8'd17, 8'd128, 8'd235, 8'd255};
        if ($urandom_range(0, 9) < 2) begin
            return edges[$urandom_range(0, 6)];
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    // Present one block and hold it until the block takes it.
    task automatic send_block(input t_yuv blk);
        yuv_if.valid             <= 1'b1;
        yuv_if.luma_top_left     <= blk.luma[0];
        yuv_if.luma_top_right    <= blk.luma[1];
        yuv_if.luma_bottom_left  <= blk.luma[2];
        yuv_if.luma_bottom_right <= blk.luma[3];
        yuv_if.chroma_u          <= blk.u;
        yuv_if.chroma_v          <= blk.v;
        do begin
            @(posedge clk);
        end while (!yuv_if.ready);
    endtask

    task automatic idle_gap(input int cycles);
        yuv_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Wait until every block sent so far has come out, then let the pipe settle.
    task automatic drain_pipe();
        yuv_if.valid <= 1'b0;
        @(posedge clk);
        while (board.expected_pixels.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_blue_first(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we         <= 1'b0;
        blue_first_now = value;
    endtask

    // Edge cases: all-zero and all-max fields, luma around the floor of 16,
    // chroma at both extremes, saturation on either side, alternating bits.
    task automatic send_corner_blocks();
        t_yuv list[$];
        list.push_back(make_block(0, 0, 0, 0, 0, 0));
        list.push_back(make_block(255, 255, 255, 255, 255, 255));
        list.push_back(make_block(0, 255, 0, 255, 128, 128));
        list.push_back(make_block(15, 16, 17, 235, 128, 128));
        list.push_back(make_block(16, 16, 16, 16, 0, 0));
        list.push_back(make_block(16, 16, 16, 16, 255, 255));
        list.push_back(make_block(16, 16, 16, 16, 0, 255));
        list.push_back(make_block(16, 16, 16, 16, 255, 0));
        list.push_back(make_block(255, 255, 255, 255, 0, 0));
        list.push_back(make_block(255, 255, 255, 255, 0, 255));
        list.push_back(make_block(128, 128, 128, 128, 128, 128));
        list.push_back(make_block(235, 235, 235, 235, 128, 128));
        list.push_back(make_block(17, 17, 17, 17, 128, 128));
        list.push_back(make_block(16, 16, 16, 16, 129, 129));
        list.push_back(make_block(100, 150, 200, 50, 90, 170));
        list.push_back(make_block(8'haa, 8'h55, 8'h55, 8'haa, 8'h55, 8'haa));
        list.push_back(make_block(8'h55, 8'haa, 8'haa, 8'h55, 8'haa, 8'h55));
        foreach (list[i]) begin
            send_block(list[i]);
            if ($urandom_range(0, 2) == 0) begin
                idle_gap($urandom_range(1, 3));
            end
        end
    endtask

    // Random blocks sent in bursts of random length with random gaps.
    task automatic send_random_blocks(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_block(make_block(random_sample(), random_sample(), random_sample(),
                                      random_sample(), random_sample(), random_sample()));
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_gap($urandom_range(1, 6));
            end
        end
    endtask

    // Main sequence: reset, then phases under each byte order.
    initial begin
        board                    = new();
        clk                      = 1'b0;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_wdata                = 1'b0;
        blue_first_now           = 1'b1;
        ready_cycle              = 0;
        stall_left               = 0;
        rgb_if.ready             = 1'b0;
        yuv_if.valid             = 1'b0;
        yuv_if.luma_top_left     = '0;
        yuv_if.luma_top_right    = '0;
        yuv_if.luma_bottom_left  = '0;
        yuv_if.luma_bottom_right = '0;
        yuv_if.chroma_u          = '0;
        yuv_if.chroma_v          = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Blue-first order as left by reset.
        send_corner_blocks();
        drain_pipe();

        write_blue_first(1'b0);
        send_corner_blocks();
        send_random_blocks(350);
        drain_pipe();

        write_blue_first(1'b1);
        send_random_blocks(350);
        drain_pipe();

        write_blue_first(1'b0);
        send_random_blocks(350);
        drain_pipe();

        if (board.fails == 0) begin
            $display("yuv420_to_rgb24_block_tb OK");
        end else begin
            $display("yuv420_to_rgb24_block_tb NOT OK");
        end
        $finish;
    end

    // Safety net in case the block stops moving.
    initial begin
        #2000000;
        $display("yuv420_to_rgb24_block_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
sv/y2r_pkg.sv
sv/y2r_if.sv
sv/y2r_prod.sv
sv/y2r_mix.sv
sv/y2r_sat.sv
sv/yuv420_to_rgb24_block.sv
sv/y2r_chk.sv
bench/yuv420_to_rgb24_block_tb.sv
